// ----- rtl/nbody_gravity_derivative_macros.svh -----
// Assertion macros shared by the nbody gravity derivative RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef NBODY_GRAVITY_DERIVATIVE_MACROS_SVH
`define NBODY_GRAVITY_DERIVATIVE_MACROS_SVH
`ifndef ASSERT_OFF
`define NBGD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define NBGD_ASSERT_NEVER(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
		else $error("forbidden condition seen");
`else
`define NBGD_ASSERT(lbl, clk, rstn, prop)
`define NBGD_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ----- rtl/nbgd_pkg.sv -----
// Package for the nbody gravity derivative block: request/result types, codes,
// reset values. No dependencies.
package nbgd_pkg;
	localparam int MAX_BODIES_DEF = 64;
	localparam int SKIP_W = 7;

	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_CLEAR  = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_CLOSE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] CFG_GRAV  = 2'd0;
	localparam logic [1:0] CFG_CLOSE = 2'd1;

	localparam logic [31:0] GRAV_RESET  = 32'd65536;
	localparam logic [31:0] CLOSE_RESET = 32'd6554;

	typedef struct packed {
		logic [1:0]        func;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [31:0]       body_mass;
		logic [SKIP_W-1:0] skip_index;
	} request_t;

	typedef struct packed {
		logic signed [31:0] deriv_x;
		logic signed [31:0] deriv_y;
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic [1:0]        status;
	} result_t;
endpackage

// ----- rtl/nbgd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nbgd_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/nbgd_front.sv -----
// Front end: takes requests and holds them in a two-entry queue for the engine.
// Depends on nbgd_pkg.
module nbgd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  nbgd_pkg::request_t req,
	output logic              busy,
	input  logic              pop,
	output logic              q_valid,
	output nbgd_pkg::request_t q_req
);
	import nbgd_pkg::*;

	request_t   slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, do_pop;

	assign busy    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_req   = slot_q[rd_q];
	assign push    = start && !busy;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end
endmodule

// ----- rtl/nbgd_back.sv -----
// Back end: executes append, clear and query requests against the body table.
// Depends on nbgd_pkg, nbgd_ram and the assertion macros header.
`include "nbody_gravity_derivative_macros.svh"
module nbgd_back #(
	parameter int MAX_BODIES = nbgd_pkg::MAX_BODIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  nbgd_pkg::request_t q_req,
	output logic              pop,
	input  logic [31:0]       grav_const,
	input  logic [31:0]       close_limit,
	output logic              done,
	output nbgd_pkg::result_t result
);
	import nbgd_pkg::*;

	localparam int CW    = $clog2(MAX_BODIES + 1);
	localparam int IW    = $clog2(MAX_BODIES);
	localparam int SUM_W = 35 + $clog2(MAX_BODIES);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_FETCH  = 10'b0000000010,
		S_DIFF   = 10'b0000000100,
		S_MUL    = 10'b0000001000,
		S_ACC    = 10'b0000010000,
		S_SQRT   = 10'b0000100000,
		S_DIVCHK = 10'b0001000000,
		S_DIV    = 10'b0010000000,
		S_TERM   = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	typedef enum logic [2:0] {
		MS_SQX, MS_SQY, MS_GM, MS_R2, MS_R3, MS_NX, MS_NY
	} mstep_t;

	state_t  state_q;
	mstep_t  mstep_q;
	request_t cur_q;
	logic [CW-1:0] count_q, idx_q;
	logic [1:0]    stat_q;
	logic signed [SUM_W-1:0] sx_q, sy_q;

	logic [32:0]  ax_q, ay_q, r_q;
	logic         negx_q, negy_q, big_q, axis_q;
	logic [31:0]  m_q;
	logic [64:0]  sqx_q;
	logic [63:0]  gm_q;
	logic [98:0]  den_q;
	logic [112:0] num_q, rem_q;
	logic [131:0] dsh_q;
	logic [33:0]  quo_q;
	logic [5:0]   div_cnt_q;
	logic [63:0]  sq_v_q, sq_res_q, sq_bit_q;

	logic [98:0]  mul_a_q;
	logic [32:0]  mul_b_q;
	logic [1:0]   mul_k_q;
	logic [65:0]  prod_q;
	logic [131:0] acc_q, acc_nxt;

	logic         we;
	logic [95:0]  rdata;
	logic [32:0]  dx, dy, ax, ay;
	logic [64:0]  ssum;
	logic [63:0]  sq_trial, sq_res_nxt;
	logic         sq_ge;
	logic [32:0]  r_nxt;
	logic [132:0] cap_cmp;
	logic         div_ge;
	logic [33:0]  quo_nxt, quo_fin;
	logic signed [SUM_W-1:0] term, sum_sel, sum_new;
	logic         fetch_end, fetch_skip;

	nbgd_ram #(.WIDTH(96), .DEPTH(MAX_BODIES)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[IW-1:0]),
		.wdata({q_req.body_mass, q_req.pos_y, q_req.pos_x}),
		.raddr(idx_q[IW-1:0]),
		.rdata(rdata)
	);

	assign pop = (state_q == S_IDLE) && q_valid;
	assign we  = pop && (q_req.func == FUNC_APPEND) && (32'(count_q) < MAX_BODIES);

	assign fetch_end  = (idx_q >= count_q);
	assign fetch_skip = (32'(idx_q) == 32'(cur_q.skip_index));

	always_comb begin
		dx = {cur_q.pos_x[31], cur_q.pos_x} - {rdata[31], rdata[31:0]};
		dy = {cur_q.pos_y[31], cur_q.pos_y} - {rdata[63], rdata[63:32]};
		ax = dx[32] ? (33'd0 - dx) : dx;
		ay = dy[32] ? (33'd0 - dy) : dy;

		acc_nxt = {acc_q[98:0], 33'd0} + {66'd0, prod_q};

		ssum = big_q ? ({2'b00, sqx_q[64:2]} + {2'b00, acc_nxt[64:2]})
		             : (sqx_q + acc_nxt[64:0]);

		sq_trial   = sq_res_q + sq_bit_q;
		sq_ge      = (sq_v_q >= sq_trial);
		sq_res_nxt = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);
		r_nxt      = big_q ? {sq_res_nxt[31:0], 1'b0} : {1'b0, sq_res_nxt[31:0]};

		cap_cmp = {den_q, 34'd0};
		div_ge  = ({19'd0, rem_q} >= dsh_q);
		quo_nxt = {quo_q[32:0], div_ge};
		quo_fin = (quo_nxt > 34'h200000000) ? 34'h200000000 : quo_nxt;

		term    = SUM_W'(quo_q);
		sum_sel = axis_q ? sy_q : sx_q;
		sum_new = (axis_q ? negy_q : negx_q) ? (sum_sel - term) : (sum_sel + term);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (pop) cur_q <= q_req;
			end
			S_DIFF: begin
				ax_q    <= ax;
				ay_q    <= ay;
				negx_q  <= !dx[32] && (dx != 33'd0);
				negy_q  <= !dy[32] && (dy != 33'd0);
				big_q   <= ax[32] | ax[31] | ay[32] | ay[31];
				m_q     <= rdata[95:64];
				mul_a_q <= {66'd0, ax};
				mul_b_q <= ax;
				mul_k_q <= 2'd0;
				acc_q   <= '0;
				mstep_q <= MS_SQX;
			end
			S_MUL: begin
				prod_q <= mul_a_q[mul_k_q*33 +: 33] * mul_b_q;
			end
			S_ACC: begin
				acc_q <= acc_nxt;
				if (mul_k_q != 2'd0) begin
					mul_k_q <= mul_k_q - 2'd1;
				end else begin
					acc_q <= '0;
					case (mstep_q)
						MS_SQX: begin
							sqx_q   <= acc_nxt[64:0];
							mul_a_q <= {66'd0, ay_q};
							mul_b_q <= ay_q;
							mstep_q <= MS_SQY;
						end
						MS_SQY: begin
							sq_v_q   <= ssum[63:0];
							sq_res_q <= '0;
							sq_bit_q <= 64'h4000_0000_0000_0000;
						end
						MS_GM: begin
							gm_q    <= acc_nxt[63:0];
							mul_a_q <= {66'd0, r_q};
							mul_b_q <= r_q;
							mstep_q <= MS_R2;
						end
						MS_R2: begin
							mul_a_q <= {33'd0, acc_nxt[65:0]};
							mul_b_q <= r_q;
							mul_k_q <= 2'd1;
							mstep_q <= MS_R3;
						end
						MS_R3: begin
							den_q   <= acc_nxt[98:0];
							mul_a_q <= {35'd0, gm_q};
							mul_b_q <= ax_q;
							mul_k_q <= 2'd1;
							mstep_q <= MS_NX;
						end
						MS_NX: begin
							num_q  <= {acc_nxt[96:0], 16'd0};
							axis_q <= 1'b0;
						end
						default: begin
							num_q  <= {acc_nxt[96:0], 16'd0};
							axis_q <= 1'b1;
						end
					endcase
				end
			end
			S_SQRT: begin
				if (sq_ge) sq_v_q <= sq_v_q - sq_trial;
				sq_res_q <= sq_res_nxt;
				sq_bit_q <= sq_bit_q >> 2;
				if (sq_bit_q[0]) begin
					r_q     <= r_nxt;
					mul_a_q <= {67'd0, grav_const};
					mul_b_q <= {1'b0, m_q};
					mul_k_q <= 2'd0;
					mstep_q <= MS_GM;
				end
			end
			S_DIVCHK: begin
				rem_q     <= num_q;
				dsh_q     <= {den_q, 33'd0};
				quo_q     <= ({20'd0, num_q} >= cap_cmp) ? 34'h200000000 : 34'd0;
				div_cnt_q <= 6'd33;
			end
			S_DIV: begin
				if (div_ge) rem_q <= rem_q - dsh_q[112:0];
				dsh_q     <= dsh_q >> 1;
				div_cnt_q <= div_cnt_q - 6'd1;
				quo_q     <= (div_cnt_q == 6'd0) ? quo_fin : quo_nxt;
			end
			S_TERM: begin
				if (!axis_q) begin
					mul_a_q <= {35'd0, gm_q};
					mul_b_q <= ay_q;
					mul_k_q <= 2'd1;
					mstep_q <= MS_NY;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			stat_q  <= ST_OK;
			sx_q    <= '0;
			sy_q    <= '0;
			done    <= 1'b0;
			result  <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						stat_q  <= ST_OK;
						sx_q    <= '0;
						sy_q    <= '0;
						idx_q   <= '0;
						state_q <= S_DONE;
						case (q_req.func)
							FUNC_APPEND: begin
								if (we) count_q <= count_q + CW'(1);
								else stat_q <= ST_FULL;
							end
							FUNC_CLEAR: count_q <= '0;
							FUNC_QUERY: state_q <= S_FETCH;
							default: begin
							end
						endcase
					end
				end
				S_FETCH: begin
					if (fetch_end) state_q <= S_DONE;
					else if (fetch_skip) idx_q <= idx_q + CW'(1);
					else state_q <= S_DIFF;
				end
				S_DIFF: state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (mul_k_q != 2'd0) state_q <= S_MUL;
					else if (mstep_q == MS_SQY) state_q <= S_SQRT;
					else if (mstep_q == MS_NX || mstep_q == MS_NY) state_q <= S_DIVCHK;
					else state_q <= S_MUL;
				end
				S_SQRT: begin
					if (sq_bit_q[0]) begin
						if (r_nxt <= {1'b0, close_limit}) begin
							stat_q  <= ST_CLOSE;
							idx_q   <= idx_q + CW'(1);
							state_q <= S_FETCH;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_DIVCHK: begin
					state_q <= ({20'd0, num_q} >= cap_cmp) ? S_TERM : S_DIV;
				end
				S_DIV: begin
					if (div_cnt_q == 6'd0) state_q <= S_TERM;
				end
				S_TERM: begin
					if (axis_q) begin
						sy_q    <= sum_new;
						idx_q   <= idx_q + CW'(1);
						state_q <= S_FETCH;
					end else begin
						sx_q    <= sum_new;
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					done          <= 1'b1;
					result.status <= stat_q;
					if (cur_q.func == FUNC_QUERY) begin
						result.deriv_x <= cur_q.vel_x;
						result.deriv_y <= cur_q.vel_y;
						result.accel_x <= (sx_q > SUM_W'(32'sh7fffffff)) ? 32'sh7fffffff :
						                  (sx_q < SUM_W'(32'sh80000000)) ? 32'sh80000000 :
						                  sx_q[31:0];
						result.accel_y <= (sy_q > SUM_W'(32'sh7fffffff)) ? 32'sh7fffffff :
						                  (sy_q < SUM_W'(32'sh80000000)) ? 32'sh80000000 :
						                  sy_q[31:0];
					end else begin
						result.deriv_x <= '0;
						result.deriv_y <= '0;
						result.accel_x <= '0;
						result.accel_y <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`NBGD_ASSERT(a_count_bound, clk, arst_n, 32'(count_q) <= MAX_BODIES)
	`NBGD_ASSERT(a_done_from_done, clk, arst_n, done |-> $past(state_q == S_DONE))
	`NBGD_ASSERT(a_sqrt_bit, clk, arst_n, (state_q == S_SQRT) |-> $onehot(sq_bit_q))
	`NBGD_ASSERT_NEVER(a_pop_busy, clk, arst_n, pop && (state_q != S_IDLE))
endmodule

// ----- rtl/nbody_gravity_derivative.sv -----
// Direct-sum 2D gravity derivative: append, clear, query over a body table.
// Append, clear and unused codes: the engine passes from idle straight to its done state.
// Query: per stored body, a 32-step square root and up to two 34-step divides.
// Two requests queue ahead of the engine; results cannot be stalled.
// Async active-low reset empties the table and restores config defaults.
// Depends on nbgd_pkg, nbgd_front, nbgd_back, nbgd_ram.
module nbody_gravity_derivative #(
	parameter int MAX_BODIES = nbgd_pkg::MAX_BODIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  nbgd_pkg::request_t req,
	output logic              done,
	output nbgd_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import nbgd_pkg::*;

	logic [31:0] grav_q, close_q;
	logic        pop, q_valid;
	request_t    q_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q  <= GRAV_RESET;
			close_q <= CLOSE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_GRAV) grav_q <= cfg_data;
			if (cfg_index == CFG_CLOSE) close_q <= cfg_data;
		end
	end

	nbgd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.pop    (pop),
		.q_valid(q_valid),
		.q_req  (q_req)
	);

	nbgd_back #(.MAX_BODIES(MAX_BODIES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_req      (q_req),
		.pop        (pop),
		.grav_const (grav_q),
		.close_limit(close_q),
		.done       (done),
		.result     (result)
	);
endmodule

// ----- bench/nbody_gravity_derivative_test.sv -----
// Self-checking bench for nbody_gravity_derivative: directed and random requests, config sweeps.
// A scoreboard class predicts each result from its own body table and register copy.
// Depends on nbgd_pkg and the nbody_gravity_derivative RTL.
`timescale 1ns / 100ps

module nbody_gravity_derivative_test;
	import nbgd_pkg::*;

	localparam int NBODY = MAX_BODIES_DEF;
	localparam int CYCLE_LIMIT = 40000000;
	localparam logic [6:0] NO_SKIP = 7'd64;

	class gravity_scoreboard;
		logic signed [31:0] body_x[NBODY];
		logic signed [31:0] body_y[NBODY];
		logic [31:0] body_m[NBODY];
		int body_cnt;
		logic [31:0] grav;
		logic [31:0] min_sep;
		result_t pending_results[$];
		int errors;

		function new();
			body_cnt = 0;
			grav = GRAV_RESET;
			min_sep = CLOSE_RESET;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			if (idx == CFG_GRAV)
				grav = val;
			else if (idx == CFG_CLOSE)
				min_sep = val;
		endfunction

		function bit [63:0] root_floor(bit [63:0] v);
			bit [63:0] res;
			bit [63:0] b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function longint pull_term(bit [63:0] gm, bit [63:0] ad, bit [63:0] rr, longint d);
			bit [127:0] num;
			bit [127:0] den;
			bit [127:0] q;
			num = ({64'd0, gm} * {64'd0, ad}) << 16;
			den = {64'd0, rr} * {64'd0, rr} * {64'd0, rr};
			q = num / den;
			if (q > (128'd1 << 33))
				q = 128'd1 << 33;
			return (d > 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function logic signed [31:0] clip32(longint v);
			if (v > 64'sd2147483647)
				return 32'sh7fffffff;
			if (v < -64'sd2147483648)
				return 32'sh80000000;
			return v[31:0];
		endfunction

		function result_t derive(request_t r);
			result_t o;
			longint sx, sy, dx, dy;
			bit [63:0] ax, ay, rr, gm;
			o = '0;
			sx = 0;
			sy = 0;
			case (r.func)
				FUNC_APPEND: begin
					if (body_cnt >= NBODY) begin
						o.status = ST_FULL;
					end else begin
						body_x[body_cnt] = r.pos_x;
						body_y[body_cnt] = r.pos_y;
						body_m[body_cnt] = r.body_mass;
						body_cnt++;
					end
				end
				FUNC_CLEAR: begin
					body_cnt = 0;
				end
				FUNC_QUERY: begin
					o.status = ST_OK;
					for (int i = 0; i < body_cnt; i++) begin
						if (i == r.skip_index)
							continue;
						dx = longint'(r.pos_x) - longint'(body_x[i]);
						dy = longint'(r.pos_y) - longint'(body_y[i]);
						ax = (dx < 0) ? -dx : dx;
						ay = (dy < 0) ? -dy : dy;
						if (ax >= 64'h80000000 || ay >= 64'h80000000)
							rr = root_floor(((ax * ax) >> 2) + ((ay * ay) >> 2)) << 1;
						else
							rr = root_floor(ax * ax + ay * ay);
						if (rr <= {32'd0, min_sep}) begin
							o.status = ST_CLOSE;
							continue;
						end
						gm = {32'd0, grav} * {32'd0, body_m[i]};
						sx += pull_term(gm, ax, rr, dx);
						sy += pull_term(gm, ay, rr, dy);
					end
					o.deriv_x = r.vel_x;
					o.deriv_y = r.vel_y;
					o.accel_x = clip32(sx);
					o.accel_y = clip32(sy);
				end
				default: ;
			endcase
			return o;
		endfunction

		function void note_request(request_t r);
			pending_results.insert(pending_results.size(), derive(r));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending_results.pop_front();
			if (got.deriv_x !== want.deriv_x || got.deriv_y !== want.deriv_y ||
					got.accel_x !== want.accel_x || got.accel_y !== want.accel_y ||
					got.status !== want.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp dx=%h dy=%h ax=%h ay=%h st=%0d got dx=%h dy=%h ax=%h ay=%h st=%0d",
						want.deriv_x, want.deriv_y, want.accel_x, want.accel_y, want.status,
						got.deriv_x, got.deriv_y, got.accel_x, got.accel_y, got.status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	request_t req = '0;
	logic done;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_GRAV;
	logic [31:0] cfg_data = '0;

	gravity_scoreboard sb = new();
	int cycles = 0;
	bit no_idle = 1'b0;

	nbody_gravity_derivative dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_request(req);
		end
	end

	function int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send(request_t r);
		int gap;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	function logic signed [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $signed($urandom_range(0, 20 * 65536)) - 32'sd655360;
			1: return $urandom;
			2: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
			3: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
			default: return $signed($urandom_range(0, 200)) - 32'sd100;
		endcase
	endfunction

	function logic [31:0] rand_mass();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 32'h000fffff);
			2: return 32'd0;
			3: return 32'hffffffff;
			default: return $urandom_range(65536, 100 * 65536);
		endcase
	endfunction

	function request_t mk(logic [1:0] f, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] vx, logic signed [31:0] vy, logic [31:0] m, logic [6:0] sk);
		request_t r;
		r.func = f;
		r.pos_x = x;
		r.pos_y = y;
		r.vel_x = vx;
		r.vel_y = vy;
		r.body_mass = m;
		r.skip_index = sk;
		return r;
	endfunction

	function request_t rand_body();
		return mk(FUNC_APPEND, rand_coord(), rand_coord(), $urandom, $urandom, rand_mass(),
			7'($urandom_range(0, 64)));
	endfunction

	function request_t rand_query(int n);
		logic [6:0] sk;
		sk = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, n)) : NO_SKIP;
		return mk(FUNC_QUERY, rand_coord(), rand_coord(), $urandom, $urandom, $urandom, sk);
	endfunction

	function request_t rand_noise();
		request_t r;
		r = mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, $urandom,
			7'($urandom_range(0, 64)));
		return r;
	endfunction

	logic [31:0] grav_set[6] = '{GRAV_RESET, 32'hffffffff, 32'd0, 32'h00000100, 32'h00100000, 32'h0};
	logic [31:0] close_set[6] = '{CLOSE_RESET, 32'd0, 32'hffffffff, 32'd65536, 32'd100, 32'h0};

	initial begin
		int sent;
		int nb;
		int nq;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mk(FUNC_QUERY, 32'sd0, 32'sd0, 32'sh7fffffff, 32'sh80000000, 32'd0, NO_SKIP));
		send(mk(FUNC_APPEND, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'hffffffff, 7'd0));
		send(mk(FUNC_APPEND, 32'sh7fffffff, 32'sh7fffffff, 32'sd0, 32'sd0, 32'd65536, 7'd0));
		send(mk(FUNC_APPEND, 32'sh80000000, 32'sh80000000, 32'sd0, 32'sd0, 32'd1, 7'd0));
		send(mk(FUNC_APPEND, 32'sd65536, -32'sd65536, 32'sd0, 32'sd0, 32'd0, 7'd0));
		send(mk(FUNC_QUERY, 32'sd131072, 32'sd0, 32'sd1, -32'sd1, 32'd0, NO_SKIP));
		send(mk(FUNC_QUERY, 32'sd0, 32'sd0, 32'sd5, 32'sd6, 32'd0, NO_SKIP));
		send(mk(FUNC_QUERY, 32'sd0, 32'sd0, 32'sd5, 32'sd6, 32'd0, 7'd0));
		send(mk(FUNC_QUERY, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'hffffffff, 7'd1));
		send(mk(FUNC_QUERY, 32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd0, 32'd0, 7'd3));
		send(mk(FUNC_QUERY, 32'sd100, 32'sd7000, 32'sd0, 32'sd0, 32'd0, 7'd63));
		send(mk(2'd3, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'hffffffff, 7'h7f));
		send(mk(FUNC_CLEAR, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'd0, 7'd0));
		send(mk(FUNC_QUERY, 32'sd1, 32'sd1, 32'sd2, 32'sd3, 32'd0, NO_SKIP));
		send(mk(FUNC_APPEND, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'h7fffffff, 7'd0));
		send(mk(FUNC_QUERY, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'd0, NO_SKIP));
		send(mk(FUNC_QUERY, -32'sd10000, 32'sd0, 32'sd0, 32'sd0, 32'd0, NO_SKIP));
		for (int i = 0; i < NBODY + 1; i++)
			send(mk(FUNC_APPEND, 32'(i * 3000000), -32'(i * 70000), 32'sd0, 32'sd0,
				rand_mass(), 7'd0));
		send(mk(FUNC_QUERY, 32'sd12345, -32'sd54321, 32'sd1, 32'sd2, 32'd0, 7'd10));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) begin
				grav_set[ph] = $urandom;
				close_set[ph] = $urandom_range(0, 32'h00100000);
			end
			write_reg(CFG_GRAV, grav_set[ph]);
			write_reg(CFG_CLOSE, close_set[ph]);
			sent = 0;
			while (sent < 190) begin
				no_idle = ($urandom_range(0, 4) == 0);
				if (ph == 3 && sent > 90 && sent < 100) begin
					drain();
					send(mk(FUNC_CLEAR, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'd0, 7'd0));
					for (int i = 0; i < NBODY + 2; i++)
						send(rand_body());
					send(rand_query(NBODY));
					sent += NBODY + 4;
				end else if ($urandom_range(0, 9) == 0) begin
					send(rand_noise());
					sent++;
				end else begin
					if ($urandom_range(0, 4) != 0) begin
						send(mk(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
							7'($urandom_range(0, 64))));
						sent++;
					end
					nb = $urandom_range(0, 6);
					nq = $urandom_range(1, 4);
					for (int i = 0; i < nb; i++)
						send(rand_body());
					for (int i = 0; i < nq; i++)
						send(rand_query(sb.body_cnt));
					sent += nb + nq;
				end
			end
			drain();
		end

		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/nbgd_pkg.sv
rtl/nbgd_ram.sv
rtl/nbgd_front.sv
rtl/nbgd_back.sv
rtl/nbody_gravity_derivative.sv
bench/nbody_gravity_derivative_test.sv
